// ----- design/sgbr_pkg.sv -----
package sgbr_pkg;

    // Default geometry
    localparam int SCREEN_WIDTH_DEF  = 480;
    localparam int SCREEN_HEIGHT_DEF = 272;
    localparam int GLYPH_ROWS_DEF    = 8;
    localparam int GLYPH_ADVANCE_DEF = 8;

    // Coordinate arithmetic width (covers cursor plus a full glyph of dots)
    localparam int CW = 14;

    // Highest cursor value before saturation
    localparam logic signed [CW-1:0] CURSOR_MAX = 14'sd2047;

    // RGB565 channel masks
    localparam logic [7:0] MASK_5 = 8'hF8;
    localparam logic [7:0] MASK_6 = 8'hFC;

    // Register indexes
    localparam logic [1:0] CFG_START_X = 2'd0;
    localparam logic [1:0] CFG_START_Y = 2'd1;
    localparam logic [1:0] CFG_SCALE   = 2'd2;
    localparam logic [1:0] CFG_COLOR   = 2'd3;

    // Datapath operation selected by the control word
    typedef enum logic [2:0] {
        OP_WAIT = 3'd0,
        OP_ROW  = 3'd1,
        OP_DOT  = 3'd2,
        OP_NROW = 3'd3,
        OP_DONE = 3'd4
    } t_op;

    // Jump condition of the control word
    typedef enum logic [2:0] {
        C_NEVER    = 3'd0,
        C_ALWAYS   = 3'd1,
        C_NO_ITEM  = 3'd2,
        C_COL_MORE = 3'd3,
        C_ROW_MORE = 3'd4
    } t_cond;

    typedef logic [2:0] t_pc;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_ctrl;

    typedef struct packed {
        logic accept;
        logic col_more;
        logic row_more;
        logic stall;
    } t_status;

    // Step addresses
    localparam t_pc PC_WAIT = 3'd0;
    localparam t_pc PC_ROW  = 3'd1;
    localparam t_pc PC_DOT  = 3'd2;
    localparam t_pc PC_NROW = 3'd3;
    localparam t_pc PC_DONE = 3'd4;

    // Control store: one word per step, jump taken when the condition holds
    function automatic t_ctrl ucode(input t_pc pc);
        t_ctrl w;
        case (pc)
            PC_WAIT: w = '{op: OP_WAIT, cond: C_NO_ITEM,  target: PC_WAIT};
            PC_ROW:  w = '{op: OP_ROW,  cond: C_NEVER,    target: PC_WAIT};
            PC_DOT:  w = '{op: OP_DOT,  cond: C_COL_MORE, target: PC_DOT};
            PC_NROW: w = '{op: OP_NROW, cond: C_ROW_MORE, target: PC_ROW};
            PC_DONE: w = '{op: OP_DONE, cond: C_ALWAYS,   target: PC_WAIT};
            default: w = '{op: OP_WAIT, cond: C_ALWAYS,   target: PC_WAIT};
        endcase
        return w;
    endfunction

    // Pack 8-8-8 colour to RGB565
    function automatic logic [15:0] pack565(input logic [23:0] c);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = c[23:16] & MASK_5;
        g = c[15:8] & MASK_6;
        b = c[7:0];
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

// ----- design/sgbr_seq.sv -----
module sgbr_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sgbr_pkg::t_status i_status,
    output sgbr_pkg::t_ctrl   o_ctrl
);

    sgbr_pkg::t_pc   r_pc;
    sgbr_pkg::t_pc   n_pc;
    sgbr_pkg::t_ctrl w_word;
    logic            w_take;

    assign w_word = sgbr_pkg::ucode(r_pc);
    assign o_ctrl = w_word;

    // Evaluate the jump condition
    always_comb begin
        case (w_word.cond)
            sgbr_pkg::C_NEVER:    w_take = 1'b0;
            sgbr_pkg::C_ALWAYS:   w_take = 1'b1;
            sgbr_pkg::C_NO_ITEM:  w_take = !i_status.accept;
            sgbr_pkg::C_COL_MORE: w_take = i_status.col_more;
            sgbr_pkg::C_ROW_MORE: w_take = i_status.row_more;
            default:              w_take = 1'b1;
        endcase
    end

    // Hold on stall, else jump or step
    always_comb begin
        if (i_status.stall) begin
            n_pc = r_pc;
        end else if (w_take) begin
            n_pc = w_word.target;
        end else begin
            n_pc = r_pc + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= sgbr_pkg::PC_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ----- design/scaled_glyph_block_renderer.sv -----
// A square comes out once the next visible dot is found or the glyph is
// finished; until then it is held as the pending square.
// One dot a cycle through the control program while the result side does not
// stall; a new item is taken only once the previous glyph is finished.
// Reset (synchronous, active low): cursor 0, start_x/start_y 0, scale 1,
// colour white, sequencer at its wait step, no item held.
module scaled_glyph_block_renderer #(
    parameter int SCREEN_WIDTH  = sgbr_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = sgbr_pkg::SCREEN_HEIGHT_DEF,
    parameter int GLYPH_ROWS    = sgbr_pkg::GLYPH_ROWS_DEF,
    parameter int GLYPH_ADVANCE = sgbr_pkg::GLYPH_ADVANCE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // glyph_bits[63:0]
    input  logic        i_s_tuser,   // first_char
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // block_x[8:0], block_y[17:9], block_w[21:18],
                                     // block_h[25:22], pixel_color[41:26],
                                     // next_cursor[53:42], zero[55:54]
    output logic        o_m_tuser,   // block_valid
    output logic        o_m_tlast    // last_of_char
);

    localparam int CW = sgbr_pkg::CW;
    localparam logic signed [CW-1:0] SW_C = CW'(SCREEN_WIDTH);
    localparam logic signed [CW-1:0] SH_C = CW'(SCREEN_HEIGHT);
    localparam logic [2:0] ROW_LAST = 3'(GLYPH_ROWS - 1);
    localparam logic [4:0] ADV_C = 5'(GLYPH_ADVANCE);

    typedef struct packed {
        logic [8:0] x;
        logic [8:0] y;
        logic [3:0] w;
        logic [3:0] h;
    } t_blk;

    // Configuration registers
    logic signed [11:0] r_start_x;
    logic signed [11:0] r_start_y;
    logic [3:0]         r_scale;
    logic [23:0]        r_fg_color;

    // Character state
    logic signed [11:0]   r_cursor;
    logic signed [11:0]   r_base;
    logic [63:0]          r_glyph;
    logic [2:0]           r_row;
    logic [2:0]           r_col;
    logic signed [CW-1:0] r_bx;
    logic signed [CW-1:0] r_by;
    logic [8:0]           r_y0;
    logic [3:0]           r_h;
    logic                 r_yvis;

    // Pending square and output register
    logic       r_pend_v;
    t_blk       r_pend;
    logic       r_out_v;
    logic       r_out_bv;
    logic       r_out_last;
    t_blk       r_out;
    logic [15:0] r_out_color;
    logic [11:0] r_out_next;

    sgbr_pkg::t_ctrl   w_ctrl;
    sgbr_pkg::t_status w_status;

    logic [3:0]           w_s;
    logic signed [CW-1:0] w_s_ext;
    logic [8:0]           w_adv;
    logic signed [CW-1:0] w_next_raw;
    logic signed [11:0]   w_next;
    logic [15:0]          w_color;
    logic signed [CW-1:0] w_ye;
    logic signed [CW-1:0] w_y0;
    logic signed [CW-1:0] w_y1;
    logic signed [CW-1:0] w_xe;
    logic signed [CW-1:0] w_x0;
    logic signed [CW-1:0] w_x1;
    logic                 w_dot;
    logic                 w_vis;
    logic                 w_out_busy;
    logic                 w_accept;
    logic                 w_is_dot;
    logic                 w_is_done;
    t_blk                 w_new;

    sgbr_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_ctrl   (w_ctrl)
    );

    // Effective scale, cursor advance and colour
    assign w_s        = (r_scale == 4'd0) ? 4'd1 : r_scale;
    assign w_s_ext    = $signed({{(CW-4){1'b0}}, w_s});
    assign w_adv      = 9'(ADV_C) * 9'(w_s);
    assign w_next_raw = CW'(r_base) + $signed({{(CW-9){1'b0}}, w_adv});
    assign w_next     = (w_next_raw > sgbr_pkg::CURSOR_MAX) ? 12'sd2047 : w_next_raw[11:0];
    assign w_color    = sgbr_pkg::pack565(r_fg_color);

    // Clip the current row vertically
    assign w_ye = r_by + w_s_ext;
    assign w_y0 = r_by[CW-1] ? '0 : r_by;
    assign w_y1 = (w_ye > SH_C) ? SH_C : w_ye;

    // Clip the current dot horizontally
    assign w_xe  = r_bx + w_s_ext;
    assign w_x0  = r_bx[CW-1] ? '0 : r_bx;
    assign w_x1  = (w_xe > SW_C) ? SW_C : w_xe;
    assign w_dot = r_glyph[{r_row, r_col}];
    assign w_vis = w_dot && r_yvis && (w_x1 > w_x0);

    assign w_new.x = w_x0[8:0];
    assign w_new.y = r_y0;
    assign w_new.w = 4'(w_x1 - w_x0);
    assign w_new.h = r_h;

    // Handshake and sequencer status; no item is taken during reset
    assign w_is_dot   = (w_ctrl.op == sgbr_pkg::OP_DOT);
    assign w_is_done  = (w_ctrl.op == sgbr_pkg::OP_DONE);
    assign o_s_tready = i_rst_n && (w_ctrl.op == sgbr_pkg::OP_WAIT);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_busy = r_out_v && !i_m_tready;

    assign w_status.accept   = w_accept;
    assign w_status.col_more = (r_col != 3'd7);
    assign w_status.row_more = (r_row != ROW_LAST);
    assign w_status.stall    = (w_is_dot && w_vis && r_pend_v && w_out_busy)
                               || (w_is_done && w_out_busy);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x  <= '0;
            r_start_y  <= '0;
            r_scale    <= 4'd1;
            r_fg_color <= 24'hFFFFFF;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sgbr_pkg::CFG_START_X: r_start_x  <= i_cfg_data[11:0];
                sgbr_pkg::CFG_START_Y: r_start_y  <= i_cfg_data[11:0];
                sgbr_pkg::CFG_SCALE:   r_scale    <= i_cfg_data[3:0];
                sgbr_pkg::CFG_COLOR:   r_fg_color <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Datapath steps driven by the control word
    always_ff @(posedge i_clk) begin
        case (w_ctrl.op)
            sgbr_pkg::OP_WAIT: begin
                if (w_accept) begin
                    r_glyph <= i_s_tdata;
                    r_base  <= i_s_tuser ? r_start_x : r_cursor;
                    r_by    <= CW'(r_start_y);
                    r_row   <= '0;
                end
            end
            sgbr_pkg::OP_ROW: begin
                r_bx   <= CW'(r_base);
                r_col  <= '0;
                r_y0   <= w_y0[8:0];
                r_h    <= 4'(w_y1 - w_y0);
                r_yvis <= (w_y1 > w_y0);
            end
            sgbr_pkg::OP_DOT: begin
                if (!w_status.stall) begin
                    r_bx  <= w_xe;
                    r_col <= r_col + 3'd1;
                end
            end
            sgbr_pkg::OP_NROW: begin
                r_by  <= w_ye;
                r_row <= r_row + 3'd1;
            end
            default: ;
        endcase
    end

    // Cursor: advance once the character is finished
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
        end else if (w_is_done && !w_status.stall) begin
            r_cursor <= w_next;
        end
    end

    // Pending square: hold one visible square until its successor or the end is known
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
        end else if (w_is_dot && w_vis && !w_status.stall) begin
            r_pend_v <= 1'b1;
            r_pend   <= w_new;
        end else if (w_is_done && !w_status.stall) begin
            r_pend_v <= 1'b0;
        end
    end

    // Output register: load from the pending square or an empty marker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_is_dot && w_vis && r_pend_v && !w_status.stall) begin
            r_out_v     <= 1'b1;
            r_out_bv    <= 1'b1;
            r_out_last  <= 1'b0;
            r_out       <= r_pend;
            r_out_color <= w_color;
            r_out_next  <= w_next;
        end else if (w_is_done && !w_status.stall) begin
            r_out_v     <= 1'b1;
            r_out_bv    <= r_pend_v;
            r_out_last  <= 1'b1;
            r_out       <= r_pend_v ? r_pend : '0;
            r_out_color <= r_pend_v ? w_color : '0;
            r_out_next  <= w_next;
        end else if (i_m_tready) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tuser  = r_out_bv;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {2'b00, r_out_next, r_out_color, r_out.h, r_out.w, r_out.y, r_out.x};

    // An empty marker always closes its character
    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tlast)
        else $error("empty marker without last flag");

    // A new item is taken only with no square left pending
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !r_pend_v)
        else $error("item taken while a square is pending");

    // A square that is sent has a nonzero clipped size
    a_block_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> (r_out.w != 4'd0) && (r_out.h != 4'd0))
        else $error("empty square sent as valid");

    // The finish step leaves the sequencer ready for the next item
    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_is_done && !w_status.stall |=> o_s_tready)
        else $error("sequencer did not return to its wait step");

endmodule

// ----- tb/glyph_square_checker.sv -----
module glyph_square_checker #(
    parameter int SCREEN_W    = sgbr_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_H    = sgbr_pkg::SCREEN_HEIGHT_DEF,
    parameter int GLYPH_ROWS  = sgbr_pkg::GLYPH_ROWS_DEF,
    parameter int GLYPH_STEP  = sgbr_pkg::GLYPH_ADVANCE_DEF,
    parameter int REPORT_MAX  = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [63:0] i_s_tdata,   // glyph_bits[63:0]
    input  logic        i_s_tuser,   // first_char
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [55:0] i_m_tdata,   // block_x[8:0], block_y[17:9], block_w[21:18],
                                     // block_h[25:22], pixel_color[41:26],
                                     // next_cursor[53:42], zero[55:54]
    input  logic        i_m_tuser,   // block_valid
    input  logic        i_m_tlast,   // last_of_char
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PEN_LIMIT = 2047;

    typedef struct packed {
        logic        filled;
        logic [8:0]  x;
        logic [8:0]  y;
        logic [3:0]  w;
        logic [3:0]  h;
        logic [15:0] rgb;
        logic [11:0] cursor;
        logic        last;
    } t_square;

    // Shadow of the layout registers and the pen column
    int          org_x;
    int          org_y;
    logic [3:0]  dot_size;
    logic [23:0] text_rgb;
    int          pen_x;

    t_square     pending_squares[$];
    int          bad_results;

    // Work out the squares one glyph produces and queue them in output order
    task automatic render_glyph(input logic [63:0] bits, input logic first);
        int          s;
        int          base;
        int          nxt;
        int          by;
        int          y0;
        int          y1;
        int          bx;
        int          x0;
        int          x1;
        int          n;
        logic [15:0] rgb;
        t_square     sq;
        t_square     found[64];
        s   = (dot_size == 4'd0) ? 1 : int'(dot_size);
        rgb = {text_rgb[23:19], text_rgb[15:10], text_rgb[7:3]};
        if (first) begin
            pen_x = org_x;
        end
        base = pen_x;
        nxt  = base + GLYPH_STEP * s;
        if (nxt > PEN_LIMIT) begin
            nxt = PEN_LIMIT;
        end
        n = 0;
        for (int r = 0; r < GLYPH_ROWS; r++) begin
            by = org_y + r * s;
            y0 = (by < 0) ? 0 : by;
            y1 = (by + s > SCREEN_H) ? SCREEN_H : by + s;
            for (int c = 0; c < 8; c++) begin
                if (bits[8 * r + c]) begin
                    bx = base + c * s;
                    x0 = (bx < 0) ? 0 : bx;
                    x1 = (bx + s > SCREEN_W) ? SCREEN_W : bx + s;
                    // Drop squares with nothing left on screen
                    if (x1 > x0 && y1 > y0) begin
                        sq.filled = 1'b1;
                        sq.x      = x0[8:0];
                        sq.y      = y0[8:0];
                        sq.w      = 4'(x1 - x0);
                        sq.h      = 4'(y1 - y0);
                        sq.rgb    = rgb;
                        sq.cursor = nxt[11:0];
                        sq.last   = 1'b0;
                        found[n]  = sq;
                        n++;
                    end
                end
            end
        end
        if (n == 0) begin
            // Nothing visible: a single empty marker closes the character
            sq        = '0;
            sq.cursor = nxt[11:0];
            sq.last   = 1'b1;
            pending_squares.push_back(sq);
        end else begin
            found[n - 1].last = 1'b1;
            for (int i = 0; i < n; i++) begin
                pending_squares.push_back(found[i]);
            end
        end
        pen_x = nxt;
    endtask

    function automatic void report_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // Track layout writes, predict on accepted glyphs, compare accepted squares
    always @(posedge i_clk) begin
        t_square got;
        t_square want;
        if (!i_rst_n) begin
            org_x       = 0;
            org_y       = 0;
            dot_size    = 4'd1;
            text_rgb    = 24'hFFFFFF;
            pen_x       = 0;
            bad_results = 0;
            pending_squares.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sgbr_pkg::CFG_START_X: org_x    = $signed(i_cfg_data[11:0]);
                    sgbr_pkg::CFG_START_Y: org_y    = $signed(i_cfg_data[11:0]);
                    sgbr_pkg::CFG_SCALE:   dot_size = i_cfg_data[3:0];
                    sgbr_pkg::CFG_COLOR:   text_rgb = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_s_tvalid && i_s_tready) begin
                render_glyph(i_s_tdata, i_s_tuser);
            end

            if (i_m_tvalid && i_m_tready) begin
                got.filled = i_m_tuser;
                got.x      = i_m_tdata[8:0];
                got.y      = i_m_tdata[17:9];
                got.w      = i_m_tdata[21:18];
                got.h      = i_m_tdata[25:22];
                got.rgb    = i_m_tdata[41:26];
                got.cursor = i_m_tdata[53:42];
                got.last   = i_m_tlast;
                if (pending_squares.size() == 0) begin
                    bad_results++;
                    if (bad_results <= REPORT_MAX) begin
                        $display("%0t ns: unexpected square, expected none, got %h",
                                 $time, got);
                    end
                end else begin
                    want = pending_squares.pop_front();
                    if (got !== want) begin
                        bad_results++;
                        if (bad_results <= REPORT_MAX) begin
                            report_field("block_valid", want.filled, got.filled);
                            report_field("block_x", want.x, got.x);
                            report_field("block_y", want.y, got.y);
                            report_field("block_w", want.w, got.w);
                            report_field("block_h", want.h, got.h);
                            report_field("pixel_color", want.rgb, got.rgb);
                            report_field("next_cursor", $signed(want.cursor),
                                         $signed(got.cursor));
                            report_field("last_of_char", want.last, got.last);
                            if ($isunknown(got)) begin
                                $display("%0t ns: square has unknown bits, expected %h, got %h",
                                         $time, want, got);
                            end
                        end
                    end
                end
            end
        end
        o_pending    <= pending_squares.size();
        o_fail_count <= bad_results;
    end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 120;
    localparam int DRAIN_LIMIT   = 50000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 50;
    localparam int HOLD_CYCLES   = 600;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cfg_we     = 1'b0;
    logic [1:0]  cfg_idx    = sgbr_pkg::CFG_START_X;
    logic [23:0] cfg_data   = '0;
    logic        s_tvalid   = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata    = '0;
    logic        s_tuser    = 1'b0;
    logic        m_tvalid;
    logic        m_tready   = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    int          fail_count;
    int          pending;
    int          burst_left = 0;
    logic        hold_req   = 1'b0;

    scaled_glyph_block_renderer u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    glyph_square_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Offer one glyph; open a new burst after a random gap when the last one ran out
    task automatic offer_glyph(input logic [63:0] bits, input logic first);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(20, 120)) @(posedge clk);
            end else begin
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 6);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= bits;
        s_tuser  <= first;
        do @(posedge clk); while (!s_tready);
        burst_left--;
    endtask

    // Stop offering and wait until every predicted square has come out
    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all four layout registers while the block is idle
    task automatic apply_layout(input logic [11:0] sx, input logic [11:0] sy,
                                input logic [3:0] sc, input logic [23:0] rgb);
        settle();
        cfg_we   <= 1'b1;
        cfg_idx  <= sgbr_pkg::CFG_START_X;
        cfg_data <= {12'd0, sx};
        @(posedge clk);
        cfg_idx  <= sgbr_pkg::CFG_START_Y;
        cfg_data <= {12'd0, sy};
        @(posedge clk);
        cfg_idx  <= sgbr_pkg::CFG_SCALE;
        cfg_data <= {20'd0, sc};
        @(posedge clk);
        cfg_idx  <= sgbr_pkg::CFG_COLOR;
        cfg_data <= rgb;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic logic [63:0] random_glyph();
        logic [63:0] a;
        logic [63:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return a & b;
            2:       return a & b & {$urandom, $urandom};
            3:       return a | b;
            4:       return '1;
            default: return a;
        endcase
    endfunction

    // Pick a start coordinate: mostly on screen, some near or past the edges
    function automatic logic [11:0] random_origin(input int span);
        int v;
        case ($urandom_range(0, 5))
            0, 1, 2: v = $urandom_range(0, span - 1);
            3:       v = -int'($urandom_range(1, 200));
            4:       v = $urandom_range(span - 100, 2047);
            default: v = $urandom_range(0, 4095);
        endcase
        return v[11:0];
    endfunction

    // Result side: segments of random stall density, plus one long hold-off
    initial begin : sink_pace
        int   seg_left;
        int   stall_pct;
        int   stall_left;
        int   hold_left;
        logic hold_done;
        seg_left   = 0;
        stall_pct  = 0;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (seg_left == 0) begin
                seg_left = $urandom_range(20, 300);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 20;
                    2:       stall_pct = 50;
                    default: stall_pct = 80;
                endcase
            end
            seg_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 99) < stall_pct) begin
                    stall_left = $urandom_range(1, 6);
                end
            end
        end
    end

    initial begin : stimulus
        int          drain_cycles;
        logic [11:0] sx;
        logic [11:0] sy;
        logic [3:0]  sc;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset layout: unit dots at the origin, white
        offer_glyph('1, 1'b1);
        offer_glyph('0, 1'b0);
        offer_glyph(64'h0000_0000_0000_0001, 1'b0);
        offer_glyph(64'h8000_0000_0000_0000, 1'b0);
        offer_glyph(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        offer_glyph(64'h5555_5555_5555_5555, 1'b0);

        // Zero scale, whole glyph below and left of the screen, black
        apply_layout(12'h800, 12'h7FF, 4'd0, 24'h000000);
        offer_glyph('1, 1'b1);
        offer_glyph(64'h0102_0408_1020_4080, 1'b0);

        // Largest dots clipped at the right and bottom edges
        apply_layout(12'd470, 12'd265, 4'd15, 24'hFFFFFF);
        offer_glyph('1, 1'b1);
        offer_glyph(64'h0000_0000_0000_00FF, 1'b0);

        // Clipped at the left and top edges, red only
        apply_layout(-12'sd20, -12'sd10, 4'd7, 24'hF80000);
        offer_glyph('1, 1'b1);
        offer_glyph(64'h8181_8181_8181_8181, 1'b0);
        offer_glyph(64'h0F0F_F0F0_3C3C_C3C3, 1'b0);

        // Cursor runs into saturation, then reloads
        apply_layout(12'd2000, 12'd100, 4'd15, 24'h04FC1F);
        offer_glyph(64'h0000_0000_0000_FFFF, 1'b1);
        offer_glyph(64'h0000_0000_0000_0001, 1'b0);
        offer_glyph(64'h0000_0000_0000_0001, 1'b1);

        // Opposite coordinate extremes
        apply_layout(12'h7FF, 12'h800, 4'd1, 24'h123456);
        offer_glyph('1, 1'b1);

        // Straddle the bottom edge with scale 8
        apply_layout(-12'sd8, 12'd264, 4'd8, 24'hFFFFFF);
        offer_glyph('1, 1'b1);
        offer_glyph(64'h00FF_00FF_00FF_00FF, 1'b0);

        // Full-size squares fully on screen
        apply_layout(12'd10, 12'd0, 4'd15, 24'h7F80FF);
        offer_glyph('1, 1'b1);
        offer_glyph(64'h8000_0000_0000_0001, 1'b0);

        // Random layouts, each running a string of random glyphs
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            sx = random_origin(sgbr_pkg::SCREEN_WIDTH_DEF);
            sy = random_origin(sgbr_pkg::SCREEN_HEIGHT_DEF);
            case ($urandom_range(0, 4))
                0:       sc = 4'd0;
                1:       sc = 4'd15;
                default: sc = 4'($urandom_range(1, 15));
            endcase
            apply_layout(sx, sy, sc, 24'($urandom));
            if (p == 1) begin
                hold_req <= 1'b1;
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                offer_glyph(random_glyph(), (i == 0) || ($urandom_range(0, 5) == 0));
            end
        end

        // Drain with a bound, then let the pipeline go quiet
        s_tvalid <= 1'b0;
        drain_cycles = 0;
        while (pending != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : watchdog
        #10ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- files.f -----
design/sgbr_pkg.sv
design/sgbr_seq.sv
design/scaled_glyph_block_renderer.sv
tb/glyph_square_checker.sv
tb/tb_top.sv
